### rtl/multi_slot_countdown_timer_unit_assert.svh
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_unit assertion macros
// clocked, reset-qualified implication checks for the timer bank
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_COUNTDOWN_TIMER_UNIT_ASSERT_SVH
`define MULTI_SLOT_COUNTDOWN_TIMER_UNIT_ASSERT_SVH

// same-cycle implication
`define MSCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/msct_pkg.sv
// ----------------------------------------------------------------------------
// msct_pkg
// shared codes, widths and control/status bundles of the countdown timer bank
// ----------------------------------------------------------------------------
`default_nettype none

package msct_pkg;

  localparam int unsigned SLOTS_DEF  = 16;
  localparam int unsigned MAX_EVENTS = 16;

  localparam int unsigned REQ_W = 3;
  localparam int unsigned ID_W  = 4;
  localparam int unsigned IVL_W = 16;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned PH_W  = 2;
  localparam int unsigned CNT_W = $clog2(MAX_EVENTS + 1);

  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WAIT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PAUSE  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RESUME = 3'd5;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE   = 3'd2;
  localparam logic [ST_W-1:0] ST_CANCELLED = 3'd3;
  localparam logic [ST_W-1:0] ST_BUSY      = 3'd4;
  localparam logic [ST_W-1:0] ST_PENDING   = 3'd5;
  localparam logic [ST_W-1:0] ST_FIRED     = 3'd6;

  localparam logic [PH_W-1:0] PH_RUN    = 2'd0;
  localparam logic [PH_W-1:0] PH_CANCEL = 2'd1;
  localparam logic [PH_W-1:0] PH_PAUSE  = 2'd2;
  localparam logic [PH_W-1:0] PH_OVER   = 2'd3;

  typedef struct packed {
    logic capture;
    logic set_invalid;
    logic find_step;
    logic idx_inc;
    logic cmd_read;
    logic cmd_apply;
    logic tick_read;
    logic tick_apply;
    logic push_res;
    logic push_hold_last;
  } msct_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_add;
    logic is_bad;
    logic used_at_idx;
    logic idx_last;
    logic out_free;
    logic hold_valid;
    logic tick_stall;
  } msct_sts_t;

endpackage

`default_nettype wire

### rtl/msct_dp.sv
// ----------------------------------------------------------------------------
// msct_dp
// timer bank datapath: request capture, slot store, slot evaluation, results
// ----------------------------------------------------------------------------
`default_nettype none

module msct_dp
  import msct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [REQ_W-1:0] req_type,
  input  wire logic [ID_W-1:0]  slot_id,
  input  wire logic [IVL_W-1:0] interval,
  input  wire logic             repeat_mode,
  input  wire msct_cmd_t        cmd,
  output msct_sts_t             sts,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [ST_W-1:0]       out_status,
  output logic [ID_W-1:0]       out_slot,
  output logic                  out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW = 1 + PH_W + 2 * IVL_W;

  logic [REQ_W-1:0] req_r;
  logic [ID_W-1:0]  id_r;
  logic [IVL_W-1:0] ivl_r;
  logic             rep_r;
  logic [IW-1:0]    idx_r;
  logic [SLOTS-1:0] used_r;
  logic [MW-1:0]    mem [SLOTS];
  logic [MW-1:0]    rd_r;
  logic [ST_W-1:0]  res_st_r;
  logic [ID_W-1:0]  res_slot_r;
  logic             hold_v_r;
  logic [ID_W-1:0]  hold_slot_r;
  logic [CNT_W-1:0] fire_cnt_r;
  logic             out_v_r;
  logic [ST_W-1:0]  out_st_r;
  logic [ID_W-1:0]  out_slot_r;
  logic             out_last_r;

  logic             is_cmd;
  logic             id_ok;
  logic [IW-1:0]    id_ix;
  logic             used_id;
  logic             out_free;
  logic [IVL_W-1:0] rd_rem;
  logic [IVL_W-1:0] rd_rel;
  logic [PH_W-1:0]  rd_ph;
  logic             rd_rep;
  logic [IVL_W-1:0] rem_dec;
  logic             fire;
  logic             report;
  logic             push_hold;
  logic [MW-1:0]    tick_wd;
  logic [ST_W-1:0]  c_st;
  logic [PH_W-1:0]  c_ph;
  logic             c_free;
  logic             we;
  logic [IW-1:0]    wa;
  logic [MW-1:0]    wd;
  logic             re;
  logic [IW-1:0]    ra;

  // request decode
  always_comb begin
    is_cmd  = req_r inside {[REQ_CANCEL:REQ_RESUME]};
    id_ok   = (int'(id_r) < SLOTS);
    id_ix   = IW'(id_r);
    used_id = id_ok && used_r[id_ix];
  end

  assign rd_rem  = rd_r[IVL_W-1:0];
  assign rd_rel  = rd_r[2*IVL_W-1:IVL_W];
  assign rd_ph   = rd_r[2*IVL_W+PH_W-1:2*IVL_W];
  assign rd_rep  = rd_r[MW-1];
  assign out_free = !out_v_r || out_ready;

  // tick evaluation of one slot
  always_comb begin
    rem_dec   = rd_rem - IVL_W'(1);
    fire      = (rd_ph == PH_RUN) && (rem_dec == '0);
    report    = fire && (fire_cnt_r < CNT_W'(MAX_EVENTS));
    push_hold = cmd.tick_apply && report && hold_v_r;
    tick_wd   = rd_r;
    if (rd_ph == PH_RUN) begin
      tick_wd[IVL_W-1:0] = (fire && rd_rep) ? rd_rel : rem_dec;
      if (fire && !rd_rep) begin
        tick_wd[2*IVL_W+PH_W-1:2*IVL_W] = PH_OVER;
      end
    end
  end

  // slot command evaluation
  always_comb begin
    c_st   = ST_OK;
    c_ph   = rd_ph;
    c_free = 1'b0;
    case (req_r)
      REQ_CANCEL: begin
        if (rd_ph == PH_CANCEL) begin
          c_st = ST_CANCELLED;
        end else if (rd_ph == PH_OVER) begin
          c_st = ST_BUSY;
        end else begin
          c_ph = PH_CANCEL;
        end
      end
      REQ_WAIT: begin
        if (rd_rep || rd_ph == PH_PAUSE) begin
          c_st = ST_BUSY;
        end else if (rd_ph == PH_RUN) begin
          c_st = ST_PENDING;
        end else begin
          c_free = 1'b1;
        end
      end
      REQ_PAUSE: begin
        if (rd_rep) begin
          c_st = ST_BUSY;
        end else if (rd_ph == PH_CANCEL) begin
          c_st = ST_CANCELLED;
        end else if (rd_ph != PH_RUN) begin
          c_st = ST_BUSY;
        end else begin
          c_ph = PH_PAUSE;
        end
      end
      default: begin
        if (rd_rep) begin
          c_st = ST_BUSY;
        end else if (rd_ph == PH_CANCEL) begin
          c_st = ST_CANCELLED;
        end else if (rd_ph != PH_PAUSE) begin
          c_st = ST_BUSY;
        end else begin
          c_ph = PH_RUN;
        end
      end
    endcase
  end

  // slot store port control
  always_comb begin
    we = 1'b0;
    wa = idx_r;
    wd = tick_wd;
    if (cmd.find_step && !used_r[idx_r]) begin
      we = 1'b1;
      wd = {rep_r, PH_RUN, ivl_r, ivl_r};
    end else if (cmd.cmd_apply) begin
      we = 1'b1;
      wa = id_ix;
      wd = {rd_rep, c_ph, rd_rel, rd_rem};
    end else if (cmd.tick_apply) begin
      we = 1'b1;
    end
    re = cmd.cmd_read || cmd.tick_read;
    ra = cmd.cmd_read ? id_ix : idx_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  // captured request and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= req_type;
      id_r  <= slot_id;
      ivl_r <= interval;
      rep_r <= repeat_mode;
    end
    if (cmd.set_invalid) begin
      res_st_r   <= ST_INVALID;
      res_slot_r <= '0;
    end else if (cmd.find_step) begin
      res_st_r   <= used_r[idx_r] ? ST_NOSPACE : ST_OK;
      res_slot_r <= used_r[idx_r] ? '0 : ID_W'(idx_r);
    end else if (cmd.cmd_apply) begin
      res_st_r   <= c_st;
      res_slot_r <= '0;
    end
    if (cmd.tick_apply && report) begin
      hold_slot_r <= ID_W'(idx_r);
    end
    if (cmd.push_res) begin
      out_st_r   <= res_st_r;
      out_slot_r <= res_slot_r;
      out_last_r <= 1'b1;
    end else if (cmd.push_hold_last || push_hold) begin
      out_st_r   <= ST_FIRED;
      out_slot_r <= hold_slot_r;
      out_last_r <= cmd.push_hold_last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      used_r     <= '0;
      hold_v_r   <= 1'b0;
      fire_cnt_r <= '0;
      out_v_r    <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx_r      <= '0;
        hold_v_r   <= 1'b0;
        fire_cnt_r <= '0;
      end else begin
        if (cmd.idx_inc) begin
          idx_r <= idx_r + IW'(1);
        end
        if (cmd.tick_apply && report) begin
          hold_v_r   <= 1'b1;
          fire_cnt_r <= fire_cnt_r + CNT_W'(1);
        end else if (cmd.push_hold_last) begin
          hold_v_r <= 1'b0;
        end
      end
      if (cmd.find_step && !used_r[idx_r]) begin
        used_r[idx_r] <= 1'b1;
      end
      if (cmd.cmd_apply && c_free) begin
        used_r[id_ix] <= 1'b0;
      end
      if (cmd.push_res || cmd.push_hold_last || push_hold) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.is_tick     = (req_r == REQ_TICK);
    sts.is_add      = (req_r == REQ_ADD);
    sts.is_bad      = !(sts.is_tick || sts.is_add || is_cmd)
                      || (sts.is_add && ivl_r == '0)
                      || (is_cmd && !used_id);
    sts.used_at_idx = used_r[idx_r];
    sts.idx_last    = (idx_r == IW'(SLOTS - 1));
    sts.out_free    = out_free;
    sts.hold_valid  = hold_v_r;
    sts.tick_stall  = report && hold_v_r && !out_free;
  end

  assign out_valid  = out_v_r;
  assign out_status = out_st_r;
  assign out_slot   = out_slot_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

### rtl/msct_ctrl.sv
// ----------------------------------------------------------------------------
// msct_ctrl
// request sequencer: decode, slot scans, slot updates and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module msct_ctrl
  import msct_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire msct_sts_t sts,
  output msct_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_CMD,
    S_TSCAN,
    S_TEVAL,
    S_FLUSH,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_bad) begin
          cmd.set_invalid = 1'b1;
          state_nxt       = S_RESULT;
        end else if (sts.is_tick) begin
          state_nxt = S_TSCAN;
        end else if (sts.is_add) begin
          state_nxt = S_FIND;
        end else begin
          cmd.cmd_read = 1'b1;
          state_nxt    = S_CMD;
        end
      end
      S_FIND: begin
        if (!sts.used_at_idx || sts.idx_last) begin
          cmd.find_step = 1'b1;
          state_nxt     = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CMD: begin
        cmd.cmd_apply = 1'b1;
        state_nxt     = S_RESULT;
      end
      S_TSCAN: begin
        if (sts.used_at_idx) begin
          cmd.tick_read = 1'b1;
          state_nxt     = S_TEVAL;
        end else if (sts.idx_last) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_TEVAL: begin
        if (!sts.tick_stall) begin
          cmd.tick_apply = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_FLUSH;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_TSCAN;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.hold_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.push_hold_last = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.push_res = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

### rtl/multi_slot_countdown_timer_unit.sv
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_unit
// bank of countdown timer slots driven by tick, add and slot commands
// ----------------------------------------------------------------------------
// One request is taken at a time. A cancel, wait, pause or resume reads and
// writes its slot once, an add searches slot by slot for the lowest free slot,
// and a tick scans every slot, where each used slot costs a read and a write
// of the slot store. Output back-pressure can hold up any request. Every
// request but a tick gives one status transaction; a tick gives one fired
// transaction per expiring slot in slot order (at most 16), tlast on the final
// one, and nothing if no slot expires. The last result waits in an output
// register while the next request is taken. The slot store needs no clearing
// after reset.
`default_nettype none

`include "multi_slot_countdown_timer_unit_assert.svh"

module multi_slot_countdown_timer_unit
  import msct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // slot_id[3:0], interval[19:4], repeat_mode[20]
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // slot_num[3:0]
  output logic [2:0]       out_tuser,  // status[2:0]
  output logic             out_tlast
);

  msct_cmd_t       cmd;
  msct_sts_t       sts;
  logic [ID_W-1:0] slot_num;

  msct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msct_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_type    (in_tuser),
    .slot_id     (in_tdata[3:0]),
    .interval    (in_tdata[19:4]),
    .repeat_mode (in_tdata[20]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_slot    (slot_num),
    .out_last    (out_tlast)
  );

  assign out_tdata = {4'b0000, slot_num};

  `MSCT_ASSERT_IMP(a_push_has_room, clk, rst_n, cmd.push_res || cmd.push_hold_last, sts.out_free, "result pushed over an untaken result")
  `MSCT_ASSERT_IMP(a_status_is_last, clk, rst_n, out_tvalid && out_tuser != ST_FIRED, out_tlast, "status result without tlast")
  `MSCT_ASSERT_NXT(a_one_request, clk, rst_n, in_tvalid && in_tready, !in_tready, "request taken while another is in work")

endmodule

`default_nettype wire

### test/multi_slot_countdown_timer_unit_checker.sv
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_unit_checker
// Watches both streams of the timer bank. Each request accepted on the input
// stream is run through a behavioural copy of the slot bank, and the status
// and fired events it should cause are queued in order. Each transaction on
// the result stream is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module multi_slot_countdown_timer_unit_checker
  import msct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // slot_id[3:0], interval[19:4], repeat_mode[20]
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // slot_num[3:0]
  input  logic [2:0]  out_tuser,  // status[2:0]
  input  logic        out_tlast,
  output int          fail_count,
  output int          outstanding,
  output int          checked_count
);

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] slot;
    logic            last;
  } timer_result_t;

  timer_result_t    due_results[$];

  logic             slot_taken  [SLOTS_DEF];
  logic [PH_W-1:0]  slot_state  [SLOTS_DEF];
  logic [IVL_W-1:0] slot_reload [SLOTS_DEF];
  logic [IVL_W-1:0] slot_count  [SLOTS_DEF];
  logic             slot_repeat [SLOTS_DEF];

  int fails;
  int checked;

  task automatic push_result(input logic [ST_W-1:0] st, input logic [ID_W-1:0] slot,
                             input logic last);
    timer_result_t r;
    r.status = st;
    r.slot   = slot;
    r.last   = last;
    due_results.push_back(r);
  endtask

  task automatic run_tick();
    int fired;
    fired = 0;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      if (slot_taken[i] && slot_state[i] == PH_RUN) begin
        slot_count[i] = slot_count[i] - 1'b1;
        if (slot_count[i] == '0) begin
          if (fired < MAX_EVENTS) begin
            push_result(ST_FIRED, i[ID_W-1:0], 1'b0);
            fired++;
          end
          if (slot_repeat[i]) slot_count[i] = slot_reload[i];
          else slot_state[i] = PH_OVER;
        end
      end
    end
    if (fired > 0) due_results[due_results.size()-1].last = 1'b1;
  endtask

  task automatic run_add(input logic [IVL_W-1:0] ivl, input logic rep);
    logic done;
    done = 1'b0;
    if (ivl == '0) begin
      push_result(ST_INVALID, '0, 1'b1);
    end else begin
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (!done && !slot_taken[i]) begin
          slot_taken[i]  = 1'b1;
          slot_state[i]  = PH_RUN;
          slot_reload[i] = ivl;
          slot_count[i]  = ivl;
          slot_repeat[i] = rep;
          push_result(ST_OK, i[ID_W-1:0], 1'b1);
          done = 1'b1;
        end
      end
      if (!done) push_result(ST_NOSPACE, '0, 1'b1);
    end
  endtask

  function automatic logic [ST_W-1:0] run_command(input logic [REQ_W-1:0] req,
                                                  input logic [ID_W-1:0] id);
    logic [PH_W-1:0] ph;
    if (int'(id) >= SLOTS_DEF || !slot_taken[id]) return ST_INVALID;
    ph = slot_state[id];
    case (req)
      REQ_CANCEL: begin
        if (ph == PH_CANCEL) return ST_CANCELLED;
        if (ph == PH_OVER) return ST_BUSY;
        slot_state[id] = PH_CANCEL;
        return ST_OK;
      end
      REQ_WAIT: begin
        if (slot_repeat[id] || ph == PH_PAUSE) return ST_BUSY;
        if (ph == PH_RUN) return ST_PENDING;
        slot_taken[id] = 1'b0;
        return ST_OK;
      end
      REQ_PAUSE: begin
        if (slot_repeat[id]) return ST_BUSY;
        if (ph == PH_CANCEL) return ST_CANCELLED;
        if (ph != PH_RUN) return ST_BUSY;
        slot_state[id] = PH_PAUSE;
        return ST_OK;
      end
      default: begin
        if (slot_repeat[id]) return ST_BUSY;
        if (ph == PH_CANCEL) return ST_CANCELLED;
        if (ph != PH_PAUSE) return ST_BUSY;
        slot_state[id] = PH_RUN;
        return ST_OK;
      end
    endcase
  endfunction

  task automatic apply_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                               input logic [IVL_W-1:0] ivl, input logic rep);
    case (req)
      REQ_TICK: run_tick();
      REQ_ADD:  run_add(ivl, rep);
      REQ_CANCEL, REQ_WAIT, REQ_PAUSE, REQ_RESUME: push_result(run_command(req, id), '0, 1'b1);
      default:  push_result(ST_INVALID, '0, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin : monitor
    timer_result_t want;
    if (!rst_n) begin
      due_results.delete();
      for (int i = 0; i < SLOTS_DEF; i++) begin
        slot_taken[i]  = 1'b0;
        slot_state[i]  = PH_RUN;
        slot_reload[i] = '0;
        slot_count[i]  = '0;
        slot_repeat[i] = 1'b0;
      end
      fails   = 0;
      checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        checked++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result transaction, status %0d slot %0d last %0d",
                   $time, out_tuser, out_tdata[ID_W-1:0], out_tlast);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (out_tuser != want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_tuser);
            fails++;
          end
          if (out_tdata[ID_W-1:0] != want.slot) begin
            $display("%0t: slot_num mismatch, expected %0d, got %0d",
                     $time, want.slot, out_tdata[ID_W-1:0]);
            fails++;
          end
          if (out_tlast != want.last) begin
            $display("%0t: tlast mismatch, expected %0d, got %0d",
                     $time, want.last, out_tlast);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready)
        apply_request(in_tuser, in_tdata[ID_W-1:0], in_tdata[ID_W+IVL_W-1:ID_W],
                      in_tdata[ID_W+IVL_W]);
    end
    fail_count    <= fails;
    outstanding   <= due_results.size();
    checked_count <= checked;
  end

endmodule

### test/tb_multi_slot_countdown_timer_unit.sv
// ----------------------------------------------------------------------------
// tb_multi_slot_countdown_timer_unit
// Drives the timer bank with a directed pass over every request and every
// status but ST_NOSPACE, then with random episodes: bursts of adds that fill the
// bank, runs of ticks, slot commands aimed mostly at live slots, sweeps that
// free slots and raw noise. Both streams idle and stall at random; the checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_multi_slot_countdown_timer_unit;
  import msct_pkg::*;

  localparam int RANDOM_ITEMS = 280;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int REP_BUDGET   = 8;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;  // slot_id[3:0], interval[19:4], repeat_mode[20]
  logic [2:0]  in_tuser   = '0;  // req_type[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // slot_num[3:0]
  logic [2:0]  out_tuser;        // status[2:0]
  logic        out_tlast;

  logic        stall_on   = 1'b1;
  int          stall_left = 0;
  int          fail_count;
  int          outstanding;
  int          checked_count;

  int          cycle_cnt  = 0;
  int          sent_count = 0;
  int          tick_count = 0;
  int          add_count  = 0;
  int          rep_added  = 0;
  bit          burst      = 1'b0;
  bit          paused_once = 1'b0;

  multi_slot_countdown_timer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  multi_slot_countdown_timer_unit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin : ready_gen
    int r;
    r = $urandom_range(0, 99);
    if (!stall_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (r < 15) begin
      out_tready <= 1'b0;
      stall_left <= (r < 3) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IVL_W-1:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return IVL_W'($urandom_range(1, 6));
    if (r < 90) return IVL_W'($urandom_range(1, 65535));
    if (r < 95) return '0;
    return IVL_W'($urandom_range(32768, 65535));
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                              input logic [IVL_W-1:0] ivl, input logic rep);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, rep, ivl, id};
    do @(posedge clk); while (!in_tready);
    sent_count++;
    if (req == REQ_TICK) tick_count++;
    if (req == REQ_ADD) begin
      add_count++;
      if (rep) rep_added++;
    end
  endtask

  task automatic send_add(input logic [IVL_W-1:0] ivl);
    logic rep;
    rep = (rep_added < REP_BUDGET) && ($urandom_range(0, 5) == 0);
    send_request(REQ_ADD, ID_W'($urandom_range(0, 15)), ivl, rep);
  endtask

  task automatic send_command();
    logic [REQ_W-1:0] req;
    logic [ID_W-1:0]  id;
    req = REQ_W'($urandom_range(REQ_CANCEL, REQ_RESUME));
    id  = ID_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 15));
    send_request(req, id, IVL_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise();
    logic [REQ_W-1:0] req;
    logic             rep;
    req = REQ_W'($urandom_range(0, 7));
    rep = 1'($urandom_range(0, 1));
    if (req == REQ_ADD && rep_added >= REP_BUDGET) rep = 1'b0;
    send_request(req, ID_W'($urandom_range(0, 15)), IVL_W'($urandom), rep);
  endtask

  initial begin : stimulus
    int start_count;
    int pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass
    send_request(REQ_TICK,       4'd0,  16'd0,     1'b0);
    send_request(REQ_CANCEL,     4'd0,  16'd0,     1'b0);
    send_request(REQ_WAIT,       4'd15, 16'hffff,  1'b1);
    send_request(REQ_PAUSE,      4'd7,  16'd0,     1'b0);
    send_request(REQ_RESUME,     4'd8,  16'd0,     1'b0);
    send_request(REQ_UNKNOWN_LO, 4'd0,  16'd1,     1'b0);
    send_request(REQ_UNKNOWN_HI, 4'd15, 16'hffff,  1'b1);
    send_request(REQ_ADD,        4'd0,  16'd0,     1'b0);
    send_request(REQ_ADD,        4'd0,  16'd1,     1'b0);
    send_request(REQ_ADD,        4'd15, 16'hffff,  1'b1);
    send_request(REQ_ADD,        4'd0,  16'd2,     1'b1);
    send_request(REQ_ADD,        4'd0,  16'd3,     1'b0);
    send_request(REQ_WAIT,       4'd0,  16'd0,     1'b0);
    send_request(REQ_PAUSE,      4'd1,  16'd0,     1'b0);
    send_request(REQ_PAUSE,      4'd3,  16'd0,     1'b0);
    send_request(REQ_WAIT,       4'd3,  16'd0,     1'b0);
    send_request(REQ_TICK,       4'd0,  16'd0,     1'b0);
    send_request(REQ_TICK,       4'd0,  16'd0,     1'b0);
    send_request(REQ_PAUSE,      4'd0,  16'd0,     1'b0);
    send_request(REQ_RESUME,     4'd3,  16'd0,     1'b0);
    send_request(REQ_RESUME,     4'd3,  16'd0,     1'b0);
    send_request(REQ_CANCEL,     4'd3,  16'd0,     1'b0);
    send_request(REQ_PAUSE,      4'd3,  16'd0,     1'b0);
    send_request(REQ_RESUME,     4'd3,  16'd0,     1'b0);
    send_request(REQ_CANCEL,     4'd3,  16'd0,     1'b0);
    send_request(REQ_WAIT,       4'd3,  16'd0,     1'b0);
    send_request(REQ_CANCEL,     4'd0,  16'd0,     1'b0);
    send_request(REQ_WAIT,       4'd0,  16'd0,     1'b0);
    send_request(REQ_WAIT,       4'd2,  16'd0,     1'b0);

    // random episodes
    start_count = sent_count;
    while (sent_count - start_count < RANDOM_ITEMS) begin
      if (!paused_once && sent_count - start_count >= RANDOM_ITEMS / 2) begin
        // hold off until every outstanding result has drained
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        paused_once = 1'b1;
      end
      burst = ($urandom_range(0, 4) == 0);
      stall_on <= ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        for (int i = 0; i < SLOTS_DEF; i++) begin
          if ($urandom_range(0, 2) == 0 || i == SLOTS_DEF - 1) begin
            if ($urandom_range(0, 1))
              send_request(REQ_CANCEL, ID_W'(i), IVL_W'($urandom), 1'b0);
            send_request(REQ_WAIT, ID_W'(i), IVL_W'($urandom), 1'b0);
          end
        end
      end else if (pick < 20) begin
        repeat ($urandom_range(3, 17)) send_add(IVL_W'($urandom_range(1, 4)));
      end else if (pick < 38) begin
        repeat ($urandom_range(1, 4))
          send_request(REQ_TICK, ID_W'($urandom), IVL_W'($urandom), 1'b0);
      end else if (pick < 75) begin
        send_command();
      end else if (pick < 88) begin
        send_add(pick_interval());
      end else begin
        send_noise();
      end
    end

    in_tvalid <= 1'b0;
    stall_on  <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests (%0d ticks, %0d adds, %0d repeating adds)",
             sent_count, tick_count, add_count, rep_added);
    $display("checked %0d result transactions, %0d mismatches", checked_count, fail_count);
    if (outstanding != 0)
      $display("%0d expected results never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
